// ===== rtl/session_packet_buffer_framer_top_assert.svh =====
// assertion macros for the session packet buffer framer
`ifndef SESSION_PACKET_BUFFER_FRAMER_TOP_ASSERT_SVH
`define SESSION_PACKET_BUFFER_FRAMER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SPBF_ASSERT_NOW(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("spbf assertion failed");
`define SPBF_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("spbf assertion failed");
`else
`define SPBF_ASSERT_NOW(label, cond)
`define SPBF_ASSERT_NEXT(label, pre, post)
`endif
`endif

// ===== rtl/spbf_pkg.sv =====
// shared constants and codes for the session packet buffer framer
package spbf_pkg;
  localparam int MAX_PACKETS       = 64;
  localparam int MAX_PACKET_BYTES  = 256;
  localparam int END_FRAME_REPEATS = 50;
  localparam int STORE_SIZE        = MAX_PACKETS * MAX_PACKET_BYTES;
  localparam int STORE_AW          = $clog2(STORE_SIZE);
  localparam int SLOT_AW           = $clog2(MAX_PACKETS);
  localparam int CFG_IW            = 2;
  localparam int CFG_DW            = 9;

  localparam logic [1:0] OP_RX   = 2'd0;
  localparam logic [1:0] OP_LOAD = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  localparam logic [CFG_IW-1:0] REG_BUFFER_PACKETS = 2'd0;
  localparam logic [CFG_IW-1:0] REG_PACKET_BYTES   = 2'd1;
  localparam logic [CFG_IW-1:0] REG_GUARD_LENGTH   = 2'd2;

  localparam logic [7:0] BYTE_FF     = 8'hFF;
  localparam logic [7:0] CODE_LOW    = 8'h0A;
  localparam logic [7:0] CODE_HIGH   = 8'h1A;
  localparam logic [7:0] FLAG_END    = 8'h01;
  localparam logic [7:0] MIN_GUARD   = 8'd6;
endpackage

// ===== rtl/spbf_in_if.sv =====
// input channel: operation and byte
interface spbf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] byte_value;
  modport source (output valid, output operation, output byte_value, input ready);
  modport sink (input valid, input operation, input byte_value, output ready);
endinterface

// ===== rtl/spbf_out_if.sv =====
// output channel: one result per transaction
interface spbf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       tx_valid;
  logic       taken;
  logic       loading;
  modport source (output valid, output tx_byte, output tx_valid, output taken,
                  output loading, input ready);
  modport sink (input valid, input tx_byte, input tx_valid, input taken,
                input loading, output ready);
endinterface

// ===== rtl/session_packet_buffer_framer_top.sv =====
// session packet buffer framer: receive detector, packet loader and framer
//
// channel  | dir | payload
// in_ch    | in  | operation, byte_value
// out_ch   | out | tx_byte, tx_valid, taken, loading
// cfg      | in  | cfg_we, cfg_index, cfg_data
//
// each transaction passes through accept, memory read, update and result post steps;
// the registered read of the packet store and slot tag memories sets this.
// after reset and after every session request a clearing pass walks the packet
// store's 16384 entries, one entry a cycle; no input is accepted meanwhile.
// a result waiting on out_ch holds the next result in its post step, and input with it.
module session_packet_buffer_framer_top (
  input  logic                        clk,
  input  logic                        rst,
  spbf_in_if.sink                     in_ch,
  spbf_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [spbf_pkg::CFG_IW-1:0] cfg_index,
  input  logic [spbf_pkg::CFG_DW-1:0] cfg_data
);
  import spbf_pkg::*;
  `include "session_packet_buffer_framer_top_assert.svh"

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_EXEC, S_FINISH} state_t;
  typedef enum logic [1:0] {RX_IDLE, RX_ID, RX_NUMBER, RX_SESSION} rx_phase_t;
  typedef enum logic [2:0] {TX_INIT, TX_MANAGE, TX_HEADER, TX_DATA, TX_GUARD,
                            TX_END_HEADER, TX_END_NUMBER} tx_phase_t;

  state_t state;
  logic [STORE_AW-1:0] clr_cnt;

  logic [6:0] buffer_packets;
  logic [8:0] packet_bytes;
  logic [7:0] guard_length;

  logic [7:0] store_mem [STORE_SIZE];
  logic [7:0] tag_mem [MAX_PACKETS];
  logic [7:0] store_rd, tag_rd;
  logic [STORE_AW-1:0] store_raddr, store_waddr;

  logic [1:0] op;
  logic [7:0] in_byte;
  logic [7:0] res_byte;
  logic       res_taken;
  logic       req_pending;

  rx_phase_t rx_phase;
  logic [2:0] rx_position, rx_matches;
  logic [7:0] number_copies [3];
  logic [7:0] expected_session;
  logic       load_active;
  logic [8:0] load_position;
  logic [SLOT_AW-1:0] load_slot;
  logic [7:0] load_tag;
  logic [6:0] loaded_count;
  logic [7:0] final_tag;
  logic       data_ended, header_select, transmit_enable;
  tx_phase_t  tx_phase;
  logic [SLOT_AW-1:0] tx_slot;
  logic [2:0] tx_header_pos;
  logic [7:0] tx_data_pos, tx_guard_pos;
  logic [1:0] tx_final_pos;
  logic [5:0] end_frames_sent;

  logic [6:0] used_packets;
  logic [8:0] used_bytes;
  logic [7:0] used_guard;
  logic [2:0] rx_pos_inc, rx_id_m, rx_ses_m;
  logic [9:0] lp_inc;
  logic [6:0] ls_inc, ts_inc;
  logic [SLOT_AW-1:0] tx_slot_adv;
  logic [8:0] dp_inc, gp_inc;
  logic [2:0] hp_inc;
  logic [1:0] fp_inc;
  logic [5:0] efs_inc;
  logic [14:0] tick_addr, load_addr;
  logic       out_free, store_we, tag_we, rx_ok, load_ok;
  logic       session_hit, post;
  logic [7:0] code;
  logic [7:0] tick_byte;

  always_comb begin
    used_packets = (buffer_packets == 7'd0) ? 7'd1 :
                   (buffer_packets > 7'(MAX_PACKETS)) ? 7'(MAX_PACKETS) : buffer_packets;
    used_bytes = (packet_bytes == 9'd0) ? 9'd1 :
                 (packet_bytes > 9'(MAX_PACKET_BYTES)) ? 9'(MAX_PACKET_BYTES) : packet_bytes;
    used_guard = (guard_length < MIN_GUARD) ? MIN_GUARD : guard_length;
    code = header_select ? CODE_HIGH : CODE_LOW;
    rx_pos_inc = rx_position + 3'd1;
    rx_id_m = rx_matches + 3'(in_byte == BYTE_FF);
    rx_ses_m = rx_matches + 3'(in_byte == expected_session);
    lp_inc = {1'b0, load_position} + 10'd1;
    ls_inc = {1'b0, load_slot} + 7'd1;
    ts_inc = {1'b0, tx_slot} + 7'd1;
    tx_slot_adv = (ts_inc == loaded_count || ts_inc >= used_packets) ?
                  '0 : ts_inc[SLOT_AW-1:0];
    dp_inc = {1'b0, tx_data_pos} + 9'd1;
    gp_inc = {1'b0, tx_guard_pos} + 9'd1;
    hp_inc = tx_header_pos + 3'd1;
    fp_inc = tx_final_pos + 2'd1;
    efs_inc = end_frames_sent + 6'd1;
    tick_addr = 15'(tx_slot) * 15'(used_bytes) + 15'(tx_data_pos);
    load_addr = 15'(load_slot) * 15'(used_bytes) + 15'(load_position) - 15'd1;
    out_free = !out_ch.valid || out_ch.ready;
    post = (state == S_FINISH) && out_free;
    rx_ok = (op == OP_RX) && !load_active;
    load_ok = (op == OP_LOAD) && load_active;
    session_hit = rx_ok && (rx_phase == RX_SESSION) && (rx_pos_inc >= 3'd6) &&
                  (rx_ses_m > 3'd4);
    store_we = (state == S_EXEC) && load_ok && (load_position != 9'd0);
    tag_we = store_we && (lp_inc >= {1'b0, used_bytes} + 10'd1);
    case (tx_phase)
      TX_HEADER, TX_END_HEADER: begin
        if (tx_header_pos < 3'd3) begin
          tick_byte = code;
        end else begin
          tick_byte = (tx_phase == TX_HEADER) ? tag_rd : BYTE_FF;
        end
      end
      TX_DATA: tick_byte = store_rd;
      TX_END_NUMBER: tick_byte = final_tag;
      default: tick_byte = '0;
    endcase
  end

  assign in_ch.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      store_mem[clr_cnt] <= '0;
    end else if (store_we) begin
      store_mem[store_waddr] <= in_byte;
    end
    store_rd <= store_mem[store_raddr];
  end

  always_ff @(posedge clk) begin
    if (state == S_CLEAR && clr_cnt < STORE_AW'(MAX_PACKETS)) begin
      tag_mem[clr_cnt[SLOT_AW-1:0]] <= '0;
    end else if (tag_we) begin
      tag_mem[load_slot] <= load_tag;
    end
    tag_rd <= tag_mem[tx_slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_packets <= 7'd64;
      packet_bytes <= 9'd64;
      guard_length <= 8'd6;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BUFFER_PACKETS: buffer_packets <= cfg_data[6:0];
        REG_PACKET_BYTES:   packet_bytes <= cfg_data;
        REG_GUARD_LENGTH:   guard_length <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      out_ch.valid <= 1'b0;
      req_pending <= 1'b0;
      rx_phase <= RX_IDLE;
      rx_position <= '0;
      rx_matches <= '0;
      number_copies[0] <= '0;
      number_copies[1] <= '0;
      number_copies[2] <= '0;
      expected_session <= 8'd1;
      load_active <= 1'b0;
      load_position <= '0;
      load_slot <= '0;
      load_tag <= 8'd1;
      loaded_count <= '0;
      final_tag <= '0;
      data_ended <= 1'b0;
      header_select <= 1'b1;
      transmit_enable <= 1'b1;
      tx_phase <= TX_INIT;
      tx_slot <= '0;
      tx_header_pos <= '0;
      tx_data_pos <= '0;
      tx_guard_pos <= '0;
      tx_final_pos <= '0;
      end_frames_sent <= '0;
    end else begin
      if (post) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + STORE_AW'(1);
          if (clr_cnt == STORE_AW'(STORE_SIZE - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            op <= in_ch.operation;
            in_byte <= in_ch.byte_value;
            store_raddr <= tick_addr[STORE_AW-1:0];
            store_waddr <= load_addr[STORE_AW-1:0];
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          res_byte <= (op == OP_TICK) ? tick_byte : '0;
          res_taken <= rx_ok || load_ok || (op == OP_TICK);
          req_pending <= session_hit;
          state <= S_FINISH;
          if (rx_ok) begin
            case (rx_phase)
              RX_ID: begin
                if (rx_pos_inc >= 3'd3) begin
                  if (rx_id_m == 3'd3) begin
                    rx_phase <= RX_NUMBER;
                    rx_position <= '0;
                    rx_matches <= '0;
                  end else if (in_byte == BYTE_FF) begin
                    // third byte restarts the identifier search
                    rx_phase <= RX_ID;
                    rx_position <= 3'd1;
                    rx_matches <= 3'd1;
                  end else begin
                    rx_phase <= RX_IDLE;
                    rx_position <= '0;
                    rx_matches <= '0;
                  end
                end else begin
                  rx_position <= rx_pos_inc;
                  rx_matches <= rx_id_m;
                end
              end
              RX_NUMBER: begin
                number_copies[rx_position[1:0]] <= in_byte;
                if (rx_pos_inc >= 3'd3) begin
                  rx_position <= '0;
                  if (number_copies[0] == number_copies[1] && number_copies[1] == in_byte
                      && in_byte == BYTE_FF) begin
                    rx_phase <= RX_SESSION;
                  end else begin
                    rx_phase <= RX_IDLE;
                  end
                end else begin
                  rx_position <= rx_pos_inc;
                end
              end
              RX_SESSION: begin
                if (rx_pos_inc >= 3'd6) begin
                  if (rx_ses_m > 3'd4) begin
                    loaded_count <= '0;
                    load_active <= 1'b1;
                    expected_session <= (expected_session == BYTE_FF) ? 8'd1 :
                                        expected_session + 8'd1;
                    header_select <= !header_select;
                    if (data_ended) begin
                      transmit_enable <= 1'b0;
                    end
                  end
                  rx_position <= '0;
                  rx_matches <= '0;
                  rx_phase <= RX_IDLE;
                end else begin
                  rx_position <= rx_pos_inc;
                  rx_matches <= rx_ses_m;
                end
              end
              default: begin
                if (in_byte == BYTE_FF) begin
                  rx_phase <= RX_ID;
                  rx_position <= 3'd1;
                  rx_matches <= 3'd1;
                end
              end
            endcase
          end else if (load_ok) begin
            if (load_position == 9'd0) begin
              if (in_byte == FLAG_END) begin
                final_tag <= load_tag - 8'd1;
                load_tag <= 8'd1;
                load_slot <= '0;
                load_active <= 1'b0;
                data_ended <= 1'b1;
                tx_slot <= '0;
                tx_header_pos <= '0;
                tx_data_pos <= '0;
                tx_guard_pos <= '0;
                tx_phase <= TX_MANAGE;
              end
              load_position <= 9'd1;
            end else if (tag_we) begin
              loaded_count <= loaded_count + 7'd1;
              load_position <= '0;
              if (ls_inc >= used_packets) begin
                load_tag <= header_select ? 8'd1 : load_tag + 8'd1;
                load_slot <= '0;
                load_active <= 1'b0;
                tx_slot <= '0;
                tx_header_pos <= '0;
                tx_data_pos <= '0;
                tx_guard_pos <= '0;
                tx_phase <= TX_MANAGE;
              end else begin
                load_slot <= ls_inc[SLOT_AW-1:0];
                load_tag <= load_tag + 8'd1;
              end
            end else begin
              load_position <= lp_inc[8:0];
            end
          end else if (op == OP_TICK) begin
            case (tx_phase)
              TX_MANAGE: begin
                if (tag_rd != 8'd0) begin
                  tx_phase <= TX_HEADER;
                end else begin
                  tx_slot <= tx_slot_adv;
                end
              end
              TX_HEADER, TX_END_HEADER: begin
                if (hp_inc >= 3'd6) begin
                  tx_header_pos <= '0;
                  tx_phase <= (tx_phase == TX_HEADER) ? TX_DATA : TX_END_NUMBER;
                end else begin
                  tx_header_pos <= hp_inc;
                end
              end
              TX_DATA: begin
                if (dp_inc >= used_bytes) begin
                  tx_data_pos <= '0;
                  tx_phase <= TX_GUARD;
                end else begin
                  tx_data_pos <= dp_inc[7:0];
                end
              end
              TX_GUARD: begin
                if (gp_inc >= {1'b0, used_guard}) begin
                  tx_guard_pos <= '0;
                  tx_slot <= tx_slot_adv;
                  tx_phase <= (loaded_count < used_packets) ? TX_END_HEADER : TX_MANAGE;
                end else begin
                  tx_guard_pos <= gp_inc[7:0];
                end
              end
              TX_END_NUMBER: begin
                if (fp_inc >= 2'd3) begin
                  tx_final_pos <= '0;
                  if (efs_inc >= 6'(END_FRAME_REPEATS)) begin
                    end_frames_sent <= '0;
                    tx_phase <= TX_MANAGE;
                  end else begin
                    end_frames_sent <= efs_inc;
                    tx_phase <= TX_END_HEADER;
                  end
                end else begin
                  tx_final_pos <= fp_inc;
                end
              end
              default: ;
            endcase
          end
        end
        S_FINISH: begin
          if (post) begin
            out_ch.tx_byte <= res_byte;
            out_ch.tx_valid <= (op == OP_TICK) && transmit_enable;
            out_ch.taken <= res_taken;
            out_ch.loading <= load_active;
            clr_cnt <= '0;
            state <= req_pending ? S_CLEAR : S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a session request always starts a clearing pass once its result is posted
  `SPBF_ASSERT_NEXT(a_req_clears, state == S_FINISH && req_pending && out_free, state == S_CLEAR)
  // load position never runs past one packet plus its flag
  `SPBF_ASSERT_NOW(a_load_pos, load_position <= 9'(MAX_PACKET_BYTES))
  // no store write may land during a clearing pass
  `SPBF_ASSERT_NOW(a_no_write_clear, !(state == S_CLEAR && store_we))
endmodule
